### sv/gsfb_pkg.sv
// ----------------------------------------------------------------------------
// Gear/rpm segment frame builder package
// Shared types, constants and segment tables for the frame builder.
// ----------------------------------------------------------------------------
package gsfb_pkg;

   // Number of rpm digits shown per transaction (1 to 4).
   localparam int DIGIT_COUNT = 4;

   // Field widths.
   localparam int GEAR_W  = 5;
   localparam int RPM_W   = 16;
   localparam int FRAME_W = 20;
   localparam int SEG_W   = 8;
   localparam int SEL_W   = 4;

   // Step counter: steps 1..DIGIT_COUNT are the digit frames, after the gear frame.
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIGIT_COUNT);

   // Special gear values.
   localparam logic signed [GEAR_W-1:0] GEAR_BLANK = -5'sd2;
   localparam logic signed [GEAR_W-1:0] GEAR_TOP   = 5'sd9;

   // Reciprocal of ten for 16-bit operands: floor(x * 52429 / 2^19) == x / 10.
   localparam logic [16:0] RECIP_TEN   = 17'd52429;
   localparam int          RECIP_SHIFT = 19;

   // Gear segment patterns, indexed by gear + 2 (blank, r, n, 1..9).
   localparam logic [SEG_W-1:0] GEAR_SEG_TABLE [0:11] = '{
      8'h00, 8'h0A, 8'h02, 8'h60, 8'hDA, 8'hF2,
      8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
   };

   // Decimal digit segment patterns.
   localparam logic [SEG_W-1:0] NUM_SEG_TABLE [0:9] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
      8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
   };

   // Input transaction payload.
   typedef struct packed {
      logic signed [GEAR_W-1:0] gear;
      logic [RPM_W-1:0]         rpm;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               last;
   } rsp_type;

   // One frame handed from the frame engine to the output register.
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } frame_xfer_type;

   // Gear segment pattern; out-of-range gears show blank.
   function automatic logic [SEG_W-1:0] gear_pattern(input logic signed [GEAR_W-1:0] gear);
      logic [GEAR_W-1:0] offset;
      logic [SEG_W-1:0]  pat;
      offset = GEAR_W'(gear - GEAR_BLANK);
      pat    = '0;
      if (gear >= GEAR_BLANK && gear <= GEAR_TOP) begin
         pat = GEAR_SEG_TABLE[offset[3:0]];
      end
      return pat;
   endfunction

endpackage

### sv/gsfb_in_buf.sv
// ----------------------------------------------------------------------------
// Input buffer
// One-entry register that holds an input transaction until the frame
// engine takes it.
// ----------------------------------------------------------------------------
module gsfb_in_buf
   import gsfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    take,
   output logic    full,
   output req_type data
);

   logic    full_ff, full_in;
   req_type data_ff, data_in;
   logic    accept;

   // A new transaction fits when the slot is empty or is emptied this cycle.
   assign req_stall = full_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      full_in = full_ff;
      data_in = data_ff;
      if (accept) begin
         full_in = 1'b1;
         data_in = req_data;
      end else if (take) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      data_ff <= data_in;
   end

   assign full = full_ff;
   assign data = data_ff;

endmodule

### sv/gsfb_frame_engine.sv
// ----------------------------------------------------------------------------
// Frame engine
// Builds one frame per cycle while can_load is high: the gear frame, then one
// per rpm digit, peeled off a running quotient with a reciprocal multiply.
// ----------------------------------------------------------------------------
module gsfb_frame_engine
   import gsfb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           buf_full,
   input  req_type        buf_data,
   output logic           take,
   input  logic           can_load,
   output frame_xfer_type xfer
);

   logic               busy_ff, busy_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [RPM_W-1:0]   quot_ff, quot_in;
   logic [FRAME_W-1:0] hold_ff, hold_in;

   logic [31:0]        prod;
   logic [RPM_W-1:0]   quot_next;
   logic [RPM_W-1:0]   times_ten;
   logic [RPM_W-1:0]   diff;
   logic [3:0]         digit;
   logic [SEG_W-1:0]   digit_seg;
   logic [STEP_W-1:0]  digit_pos;
   logic [1:0]         digit_idx;
   logic [SEL_W-1:0]   sel;

   // Split the running quotient into its next quotient and remainder.
   assign prod      = 32'(quot_ff) * 32'(RECIP_TEN);
   assign quot_next = RPM_W'(prod[31:RECIP_SHIFT]);
   assign times_ten = RPM_W'({quot_next, 3'b000}) + RPM_W'({quot_next, 1'b0});
   assign diff      = quot_ff - times_ten;
   assign digit     = diff[3:0];

   // A digit is blank once the quotient reaches zero.
   always_comb begin
      digit_seg = '0;
      if (quot_ff != '0) begin
         digit_seg = (digit < 4'd10) ? NUM_SEG_TABLE[digit] : '0;
      end
   end

   // Active-low one-hot digit select, least significant digit first.
   assign digit_pos = step_ff - 1'b1;
   assign digit_idx = digit_pos[1:0];
   assign sel       = ~(4'b1000 >> digit_idx);

   assign take = can_load && !busy_ff && buf_full;

   // Frame sequencing.
   always_comb begin
      busy_in   = busy_ff;
      step_in   = step_ff;
      quot_in   = quot_ff;
      hold_in   = hold_ff;
      xfer      = '0;
      if (can_load && busy_ff) begin
         hold_in         = {digit_seg, sel, hold_ff[SEG_W-1:0]};
         quot_in         = quot_next;
         xfer.valid      = 1'b1;
         xfer.data.frame = hold_in;
         xfer.data.last  = (step_ff == STEP_LAST);
         step_in         = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
         end
      end else if (take) begin
         hold_in         = {hold_ff[FRAME_W-1:SEG_W], gear_pattern(buf_data.gear)};
         quot_in         = buf_data.rpm;
         xfer.valid      = 1'b1;
         xfer.data.frame = hold_in;
         xfer.data.last  = 1'b0;
         step_in         = STEP_W'(1);
         busy_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         hold_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         hold_ff <= hold_in;
      end
      quot_ff <= quot_in;
   end

endmodule

### sv/gsfb_out_reg.sv
// ----------------------------------------------------------------------------
// Output register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module gsfb_out_reg
   import gsfb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  frame_xfer_type xfer,
   output logic           can_load,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // The register can take a frame when it is empty or drains this cycle.
   assign can_load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (can_load) begin
         valid_in = xfer.valid;
         if (xfer.valid) begin
            data_in = xfer.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### sv/gear_rpm_segment_frame_builder_unit.sv
// ----------------------------------------------------------------------------
// Gear/rpm segment frame builder
// Turns each (gear, rpm) transaction into display frames for a multiplexed
// seven-segment shift-register chain.
// ----------------------------------------------------------------------------
// Each input transaction yields 1 + DIGIT_COUNT result transactions (five by
// default), one per cycle when the output is not stalled; this rate is set
// by the single frame engine, which emits one frame per cycle while the
// output can load. The first frame carries the gear pattern in bits 0-7 with
// bits 8-19 left from the previous run; each following frame selects one rpm
// digit, least significant first, with an active-low select in bits 8-11 and
// its segments in bits 12-19, and the final frame is flagged by last. A
// one-entry input buffer accepts the next transaction while frames of the
// current one are still going out. The frame register clears on reset.
// ----------------------------------------------------------------------------
module gear_rpm_segment_frame_builder_unit
   import gsfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic           take;
   logic           buf_full;
   req_type        buf_data;
   logic           can_load;
   frame_xfer_type xfer;

   // Input side buffer.
   gsfb_in_buf u_in_buf (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .take      (take),
      .full      (buf_full),
      .data      (buf_data)
   );

   // Frame generation.
   gsfb_frame_engine u_frame_engine (
      .clock    (clock),
      .reset    (reset),
      .buf_full (buf_full),
      .buf_data (buf_data),
      .take     (take),
      .can_load (can_load),
      .xfer     (xfer)
   );

   // Result register.
   gsfb_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .xfer      (xfer),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
